// ===== rtl/core/cst_pkg.sv =====
package cst_pkg;

   localparam int TIME_W       = 24;
   localparam int POS_W        = 32;
   localparam int PHASE_W      = 33;
   localparam int XY_W         = 34;
   localparam int Z_W          = 33;
   localparam int CORDIC_ITERS = 24;
   localparam int DIV_STEPS    = 24;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 24;

   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [31:0]     INV_TWO_PI  = 32'sd683565276;
   localparam logic [30:0]            ONE_Q30     = 31'd1073741824;

   // Arctangent of 2^-i, in units of 2^-32 turns.
   localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_COUNT  = 3'd0,
      CSR_SPLIT_ENABLE  = 3'd1,
      CSR_SPLIT_COUNT   = 3'd2,
      CSR_PERIOD_US     = 3'd3,
      CSR_SPLIT_TIME_US = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SETUP,
      SEQ_RUN
   } seq_state_type;

   typedef struct packed {
      logic [TIME_W-1:0] t;
      logic              last;
   } tag_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x0;
      logic signed [POS_W-1:0] y0;
      logic signed [POS_W-1:0] z0;
      logic signed [POS_W-1:0] h;
      logic signed [POS_W:0]   dx;
      logic signed [POS_W:0]   dy;
   } geom_type;

endpackage

// ===== rtl/core/cst_seq.sv =====
module cst_seq #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         en,
   input  logic [6:0]                   sample_count,
   input  logic                         split_enable,
   input  logic [5:0]                   split_count,
   input  logic [cst_pkg::TIME_W-1:0]   period,
   input  logic [cst_pkg::TIME_W-1:0]   split_time,
   output logic                         out_valid,
   output cst_pkg::tag_type             out_tag
);
   import cst_pkg::*;

   localparam int IDX_W = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
   localparam int NW    = IDX_W + 1;
   localparam int CNT_W = $clog2(DIV_STEPS);

   seq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TIME_W-1:0] a_quo_ff, a_quo_in, b_quo_ff, b_quo_in;
   logic [IDX_W-1:0]  a_rem_ff, a_rem_in, b_rem_ff, b_rem_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [TIME_W-1:0] q_ff, q_in;
   logic [IDX_W-1:0]  r_ff, r_in;

   logic [6:0]        n7, m7, sc7;
   logic              split;
   logic [IDX_W-1:0]  a_den, b_den;
   logic [NW-1:0]     a_sh, b_sh;
   logic              a_ge, b_ge;
   logic              last, seg2;
   logic [TIME_W-1:0] inc_q, q_sum;
   logic [IDX_W-1:0]  inc_r, den;
   logic [NW-1:0]     r_sum;

   always_comb begin
      n7 = (sample_count < 7'd2) ? 7'd2 :
           ((sample_count > 7'(MAX_SAMPLES)) ? 7'(MAX_SAMPLES) : sample_count);
      sc7 = {1'b0, split_count};
      m7 = (sc7 < 7'd2) ? 7'd2 : ((sc7 > n7 - 7'd1) ? n7 - 7'd1 : sc7);
      split = split_enable && (n7 >= 7'd3);
      a_den = split ? IDX_W'(m7 - 7'd1) : IDX_W'(n7 - 7'd1);
      b_den = IDX_W'(n7 - m7);
   end

   // Step increments of the sample-time accumulator, one quotient bit a cycle.
   always_comb begin
      a_sh = {a_rem_ff, a_quo_ff[TIME_W-1]};
      b_sh = {b_rem_ff, b_quo_ff[TIME_W-1]};
      a_ge = a_sh >= {1'b0, a_den};
      b_ge = b_sh >= {1'b0, b_den};
   end

   always_comb begin
      last  = {1'b0, idx_ff} == NW'(n7 - 7'd1);
      seg2  = split && ({1'b0, idx_ff} >= NW'(m7 - 7'd1));
      inc_q = seg2 ? b_quo_ff : a_quo_ff;
      inc_r = seg2 ? b_rem_ff : a_rem_ff;
      den   = seg2 ? b_den : a_den;
      r_sum = {1'b0, r_ff} + {1'b0, inc_r};
      q_sum = q_ff + inc_q;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      a_quo_in = a_quo_ff;
      b_quo_in = b_quo_ff;
      a_rem_in = a_rem_ff;
      b_rem_in = b_rem_ff;
      idx_in   = idx_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      out_valid = 1'b0;
      out_tag.t = q_ff;
      out_tag.last = last;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_SETUP;
               cnt_in   = '0;
               a_quo_in = split ? split_time : period;
               b_quo_in = period - split_time;
               a_rem_in = '0;
               b_rem_in = '0;
            end
         end
         SEQ_SETUP: begin
            a_rem_in = a_ge ? IDX_W'(a_sh - {1'b0, a_den}) : a_sh[IDX_W-1:0];
            b_rem_in = b_ge ? IDX_W'(b_sh - {1'b0, b_den}) : b_sh[IDX_W-1:0];
            a_quo_in = {a_quo_ff[TIME_W-2:0], a_ge};
            b_quo_in = {b_quo_ff[TIME_W-2:0], b_ge};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = SEQ_RUN;
               idx_in   = '0;
               q_in     = '0;
               r_in     = '0;
            end
         end
         SEQ_RUN: begin
            out_valid = 1'b1;
            if (en) begin
               if (last) begin
                  state_in = SEQ_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  if (r_sum >= {1'b0, den}) begin
                     r_in = IDX_W'(r_sum - {1'b0, den});
                     q_in = q_sum + 1'b1;
                  end else begin
                     r_in = r_sum[IDX_W-1:0];
                     q_in = q_sum;
                  end
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff   <= cnt_in;
      a_quo_ff <= a_quo_in;
      b_quo_ff <= b_quo_in;
      a_rem_ff <= a_rem_in;
      b_rem_ff <= b_rem_in;
      idx_ff   <= idx_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
   end

endmodule

// ===== rtl/core/cst_phase_div.sv =====
module cst_phase_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  cst_pkg::tag_type             in_tag,
   input  logic [cst_pkg::TIME_W-1:0]   period,
   output logic                         out_valid,
   output logic [cst_pkg::PHASE_W-1:0]  out_phase,
   output cst_pkg::tag_type             out_tag
);
   import cst_pkg::*;

   localparam int STAGES = PHASE_W;

   logic              v_ff   [STAGES];
   logic              v_in   [STAGES];
   logic [TIME_W-1:0] rem_ff [STAGES];
   logic [TIME_W-1:0] rem_in [STAGES];
   logic [PHASE_W-1:0] quo_ff [STAGES];
   logic [PHASE_W-1:0] quo_in [STAGES];
   tag_type           tag_ff [STAGES];
   tag_type           tag_in [STAGES];

   // Restoring division of t * 2^32 by the period, one quotient bit per stage.
   // The first stage settles the integer bit, which is set only when t equals the period.
   always_comb begin
      logic          ge0;
      logic [TIME_W:0] sh;
      logic          ge;
      ge0       = in_tag.t >= period;
      v_in[0]   = in_valid;
      rem_in[0] = ge0 ? in_tag.t - period : in_tag.t;
      quo_in[0] = {{(PHASE_W-1){1'b0}}, ge0};
      tag_in[0] = in_tag;
      for (int k = 1; k < STAGES; k++) begin
         sh        = {rem_ff[k-1], 1'b0};
         ge        = sh >= {1'b0, period};
         rem_in[k] = ge ? TIME_W'(sh - {1'b0, period}) : sh[TIME_W-1:0];
         quo_in[k] = {quo_ff[k-1][PHASE_W-2:0], ge};
         v_in[k]   = v_ff[k-1];
         tag_in[k] = tag_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_in[k];
         end
         if (en) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            tag_ff[k] <= tag_in[k];
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_phase = quo_ff[STAGES-1];
   assign out_tag   = tag_ff[STAGES-1];

endmodule

// ===== rtl/core/cst_cordic.sv =====
module cst_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [cst_pkg::PHASE_W-1:0]        in_phase,
   input  cst_pkg::tag_type                   in_tag,
   output logic                               out_valid,
   output logic signed [cst_pkg::XY_W-1:0]    out_cos,
   output logic signed [cst_pkg::XY_W-1:0]    out_sin,
   output logic [cst_pkg::PHASE_W-1:0]        out_phase,
   output cst_pkg::tag_type                   out_tag
);
   import cst_pkg::*;

   localparam int NS = CORDIC_ITERS + 1;

   logic                   v_ff   [NS];
   logic                   v_in   [NS];
   logic signed [XY_W-1:0] x_ff   [NS];
   logic signed [XY_W-1:0] x_in   [NS];
   logic signed [XY_W-1:0] y_ff   [NS];
   logic signed [XY_W-1:0] y_in   [NS];
   logic signed [Z_W-1:0]  z_ff   [NS];
   logic signed [Z_W-1:0]  z_in   [NS];
   logic                   neg_ff [NS];
   logic                   neg_in [NS];
   logic [PHASE_W-1:0]     ph_ff  [NS];
   logic [PHASE_W-1:0]     ph_in  [NS];
   tag_type                tag_ff [NS];
   tag_type                tag_in [NS];

   always_comb begin
      logic                   neg0;
      logic [31:0]            zr;
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic signed [Z_W-1:0]  at;
      // Angles in the left half-plane are turned by half a turn and the results negated.
      neg0      = in_phase[31] ^ in_phase[30];
      zr        = {in_phase[31] ^ neg0, in_phase[30:0]};
      v_in[0]   = in_valid;
      x_in[0]   = CORDIC_GAIN;
      y_in[0]   = '0;
      z_in[0]   = {zr[31], zr};
      neg_in[0] = neg0;
      ph_in[0]  = in_phase;
      tag_in[0] = in_tag;
      for (int k = 0; k < CORDIC_ITERS; k++) begin
         xs = x_ff[k] >>> k;
         ys = y_ff[k] >>> k;
         at = {1'b0, ATAN_TURNS[k]};
         if (!z_ff[k][Z_W-1]) begin
            x_in[k+1] = x_ff[k] - ys;
            y_in[k+1] = y_ff[k] + xs;
            z_in[k+1] = z_ff[k] - at;
         end else begin
            x_in[k+1] = x_ff[k] + ys;
            y_in[k+1] = y_ff[k] - xs;
            z_in[k+1] = z_ff[k] + at;
         end
         v_in[k+1]   = v_ff[k];
         neg_in[k+1] = neg_ff[k];
         ph_in[k+1]  = ph_ff[k];
         tag_in[k+1] = tag_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_in[k];
         end
         if (en) begin
            x_ff[k]   <= x_in[k];
            y_ff[k]   <= y_in[k];
            z_ff[k]   <= z_in[k];
            neg_ff[k] <= neg_in[k];
            ph_ff[k]  <= ph_in[k];
            tag_ff[k] <= tag_in[k];
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_cos   = neg_ff[NS-1] ? -x_ff[NS-1] : x_ff[NS-1];
   assign out_sin   = neg_ff[NS-1] ? -y_ff[NS-1] : y_ff[NS-1];
   assign out_phase = ph_ff[NS-1];
   assign out_tag   = tag_ff[NS-1];

endmodule

// ===== rtl/core/cst_mix.sv =====
module cst_mix (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [cst_pkg::XY_W-1:0]    in_cos,
   input  logic signed [cst_pkg::XY_W-1:0]    in_sin,
   input  logic [cst_pkg::PHASE_W-1:0]        in_phase,
   input  cst_pkg::tag_type                   in_tag,
   input  cst_pkg::geom_type                  geom,
   output logic                               out_valid,
   output logic signed [cst_pkg::POS_W-1:0]   out_x,
   output logic signed [cst_pkg::POS_W-1:0]   out_y,
   output logic signed [cst_pkg::POS_W-1:0]   out_z,
   output cst_pkg::tag_type                   out_tag
);
   import cst_pkg::*;

   // First stage: sine scaled by 1/(2*pi), and the lift fraction.
   logic               v1_ff;
   logic signed [65:0] sprod1_ff, sprod1_in;
   logic [30:0]        fz1_ff, fz1_in;
   logic [30:0]        quarter1_ff;
   tag_type            tag1_ff;

   // Second stage: the cycloid fraction.
   logic               v2_ff;
   logic [30:0]        fxy2_ff, fxy2_in;
   logic [30:0]        fz2_ff;
   tag_type            tag2_ff;

   // Third stage: scaled displacements.
   logic               v3_ff;
   logic signed [64:0] px3_ff, px3_in, py3_ff, py3_in;
   logic signed [63:0] pz3_ff, pz3_in;
   tag_type            tag3_ff;

   always_comb begin
      logic signed [34:0] dz;
      logic signed [34:0] hz;
      sprod1_in = in_sin * INV_TWO_PI;
      dz = $signed({4'b0, ONE_Q30}) - {in_cos[XY_W-1], in_cos};
      hz = dz >>> 1;
      if (hz[34]) begin
         fz1_in = '0;
      end else if (hz > $signed({4'b0, ONE_Q30})) begin
         fz1_in = ONE_Q30;
      end else begin
         fz1_in = hz[30:0];
      end
   end

   always_comb begin
      logic signed [33:0] sterm;
      logic signed [35:0] diff;
      sterm = sprod1_ff[65:32];
      diff  = $signed({5'b0, quarter1_ff}) - {{2{sterm[33]}}, sterm};
      if (diff[35]) begin
         fxy2_in = '0;
      end else if (diff > $signed({5'b0, ONE_Q30})) begin
         fxy2_in = ONE_Q30;
      end else begin
         fxy2_in = diff[30:0];
      end
   end

   always_comb begin
      px3_in = geom.dx * $signed({1'b0, fxy2_ff});
      py3_in = geom.dy * $signed({1'b0, fxy2_ff});
      pz3_in = geom.h * $signed({1'b0, fz2_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         sprod1_ff   <= sprod1_in;
         fz1_ff      <= fz1_in;
         quarter1_ff <= in_phase[32:2];
         tag1_ff     <= in_tag;
         fxy2_ff     <= fxy2_in;
         fz2_ff      <= fz1_ff;
         tag2_ff     <= tag1_ff;
         px3_ff      <= px3_in;
         py3_ff      <= py3_in;
         pz3_ff      <= pz3_in;
         tag3_ff     <= tag2_ff;
      end
   end

   // x and y always land between start and landing, so the sum wraps exactly.
   always_comb begin
      logic signed [33:0] zsh;
      logic signed [34:0] zsum;
      out_x = geom.x0 + px3_ff[61:30];
      out_y = geom.y0 + py3_ff[61:30];
      zsh   = pz3_ff[63:30];
      zsum  = {{3{geom.z0[POS_W-1]}}, geom.z0} + {zsh[33], zsh};
      if (zsum > 35'sd2147483647) begin
         out_z = 32'sh7FFFFFFF;
      end else if (zsum < -35'sd2147483648) begin
         out_z = 32'sh80000000;
      end else begin
         out_z = zsum[31:0];
      end
   end

   assign out_valid = v3_ff;
   assign out_tag   = tag3_ff;

endmodule

// ===== rtl/core/cycloid_swing_trajectory_gen.sv =====
// Cycloid foot swing trajectory generator.
// The request channel (req_*) takes one transaction holding a start point, a
// landing x/y and a lift height. For it the result channel (rsp_*) delivers a
// run of n points (n = sample_count clamped to 2..MAX_SAMPLES), each with its
// position, time from swing start and a flag on the final point.
// The configuration channel (csr_*) is always ready; registers must be
// written only between runs, which the block itself does not enforce.
// After a request is taken, a bit-serial divider computes the time step
// increments, then one sample per cycle, while the output does not stall,
// enters a pipeline of 62 registers (33 phase-division stages, 25 CORDIC
// stages, three arithmetic stages and the output register). The points are
// presented one per cycle while the receiver does not stall, and a
// new request is taken once the last point of the run has been delivered.
// Reset clears the configuration to its defaults and empties the pipeline.
// When a point waits and rsp_ready is low, the whole pipeline and the
// sample sequencer hold their contents; nothing is dropped or repeated.
module cycloid_swing_trajectory_gen #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [cst_pkg::POS_W-1:0]     req_start_x,
   input  logic signed [cst_pkg::POS_W-1:0]     req_start_y,
   input  logic signed [cst_pkg::POS_W-1:0]     req_start_z,
   input  logic signed [cst_pkg::POS_W-1:0]     req_land_x,
   input  logic signed [cst_pkg::POS_W-1:0]     req_land_y,
   input  logic signed [cst_pkg::POS_W-1:0]     req_lift_height,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [cst_pkg::POS_W-1:0]     rsp_point_x,
   output logic signed [cst_pkg::POS_W-1:0]     rsp_point_y,
   output logic signed [cst_pkg::POS_W-1:0]     rsp_point_z,
   output logic [cst_pkg::TIME_W-1:0]           rsp_sample_time,
   output logic                                 rsp_last_sample,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cst_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cst_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import cst_pkg::*;

   logic [6:0]        sample_count_ff;
   logic              split_enable_ff;
   logic [5:0]        split_count_ff;
   logic [TIME_W-1:0] period_ff;
   logic [TIME_W-1:0] split_time_ff;

   logic              busy_ff, busy_in;
   geom_type          geom_ff;

   logic [TIME_W-1:0] period_eff, split_eff;
   logic              en, req_take, rsp_take;

   logic              seq_valid;
   tag_type           seq_tag;
   logic              div_valid;
   logic [PHASE_W-1:0] div_phase;
   tag_type           div_tag;
   logic              cor_valid;
   logic signed [XY_W-1:0] cor_cos, cor_sin;
   logic [PHASE_W-1:0] cor_phase;
   tag_type           cor_tag;
   logic              mix_valid;
   logic signed [POS_W-1:0] mix_x, mix_y, mix_z;
   tag_type           mix_tag;

   logic              rsp_valid_ff;
   logic signed [POS_W-1:0] px_ff, py_ff, pz_ff;
   tag_type           rtag_ff;

   assign csr_ready = 1'b1;
   assign req_ready = !busy_ff;
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid_ff && rsp_ready;
   assign en        = !rsp_valid_ff || rsp_ready;

   always_comb begin
      period_eff = (period_ff == '0) ? TIME_W'(1) : period_ff;
      split_eff  = (split_time_ff > period_eff) ? period_eff : split_time_ff;
      busy_in    = busy_ff;
      if (req_take) begin
         busy_in = 1'b1;
      end else if (rsp_take && rtag_ff.last) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= 7'd64;
         split_enable_ff <= 1'b0;
         split_count_ff  <= 6'd32;
         period_ff       <= 24'd500000;
         split_time_ff   <= 24'd250000;
         busy_ff         <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SAMPLE_COUNT:  sample_count_ff <= csr_wdata[6:0];
               CSR_SPLIT_ENABLE:  split_enable_ff <= csr_wdata[0];
               CSR_SPLIT_COUNT:   split_count_ff  <= csr_wdata[5:0];
               CSR_PERIOD_US:     period_ff       <= csr_wdata[TIME_W-1:0];
               CSR_SPLIT_TIME_US: split_time_ff   <= csr_wdata[TIME_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // The request stays latched for the whole run; no new one is taken before it ends.
   always_ff @(posedge clock) begin
      if (req_take) begin
         geom_ff.x0 <= req_start_x;
         geom_ff.y0 <= req_start_y;
         geom_ff.z0 <= req_start_z;
         geom_ff.h  <= req_lift_height;
         geom_ff.dx <= {req_land_x[POS_W-1], req_land_x} - {req_start_x[POS_W-1], req_start_x};
         geom_ff.dy <= {req_land_y[POS_W-1], req_land_y} - {req_start_y[POS_W-1], req_start_y};
      end
   end

   cst_seq #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (req_take),
      .en           (en),
      .sample_count (sample_count_ff),
      .split_enable (split_enable_ff),
      .split_count  (split_count_ff),
      .period       (period_eff),
      .split_time   (split_eff),
      .out_valid    (seq_valid),
      .out_tag      (seq_tag)
   );

   cst_phase_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (seq_valid),
      .in_tag    (seq_tag),
      .period    (period_eff),
      .out_valid (div_valid),
      .out_phase (div_phase),
      .out_tag   (div_tag)
   );

   cst_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_phase  (div_phase),
      .in_tag    (div_tag),
      .out_valid (cor_valid),
      .out_cos   (cor_cos),
      .out_sin   (cor_sin),
      .out_phase (cor_phase),
      .out_tag   (cor_tag)
   );

   cst_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cor_valid),
      .in_cos    (cor_cos),
      .in_sin    (cor_sin),
      .in_phase  (cor_phase),
      .in_tag    (cor_tag),
      .geom      (geom_ff),
      .out_valid (mix_valid),
      .out_x     (mix_x),
      .out_y     (mix_y),
      .out_z     (mix_z),
      .out_tag   (mix_tag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= mix_valid;
      end
      if (en) begin
         px_ff   <= mix_x;
         py_ff   <= mix_y;
         pz_ff   <= mix_z;
         rtag_ff <= mix_tag;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = px_ff;
   assign rsp_point_y     = py_ff;
   assign rsp_point_z     = pz_ff;
   assign rsp_sample_time = rtag_ff.t;
   assign rsp_last_sample = rtag_ff.last;

endmodule
